/* hw/rtl/gtl_pkg.sv */
// Package for the greek-to-latin transliterator: request types, pending-letter
// codes and the ISO-8859-7 to ASCII lookup function.
// No dependencies.
package gtl_pkg;

    localparam int unsigned MaxChars = 4;

    typedef logic [6:0] char_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_req_t;

    typedef struct packed {
        char_t out_char;
        logic  last;
    } out_req_t;

    typedef enum logic [2:0] {
        PEND_NONE  = 3'd0,
        PEND_CAP_M = 3'd1,
        PEND_CAP_N = 3'd2,
        PEND_M     = 3'd3,
        PEND_N     = 3'd4
    } pend_t;

    // table entry: 0..3 characters
    typedef struct packed {
        logic [1:0] len;
        char_t      c0;
        char_t      c1;
        char_t      c2;
    } xlat_t;

    // characters of one request, in output order
    typedef struct packed {
        logic [2:0] cnt;
        char_t [MaxChars-1:0] chars;
    } group_t;

    function automatic xlat_t mk0();
        xlat_t r;
        r = '{len: 2'd0, c0: '0, c1: '0, c2: '0};
        return r;
    endfunction

    function automatic xlat_t mk1(input logic [7:0] a);
        xlat_t r;
        r = '{len: 2'd1, c0: a[6:0], c1: '0, c2: '0};
        return r;
    endfunction

    function automatic xlat_t mk2(input logic [7:0] a, input logic [7:0] b);
        xlat_t r;
        r = '{len: 2'd2, c0: a[6:0], c1: b[6:0], c2: '0};
        return r;
    endfunction

    function automatic xlat_t mk3(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c);
        xlat_t r;
        r = '{len: 2'd3, c0: a[6:0], c1: b[6:0], c2: c[6:0]};
        return r;
    endfunction

    function automatic xlat_t xlat(input logic [7:0] b);
        xlat_t r;
        r = mk0();
        case (b) inside
            8'd32, 8'd33, 8'd44, 8'd46, 8'd63, [8'd48:8'd57]: r = mk1(b);
            8'd182: r = mk2("'", "A");
            8'd184: r = mk2("'", "E");
            8'd185: r = mk2("'", "H");
            8'd186: r = mk2("'", "I");
            8'd188: r = mk2("'", "O");
            8'd190: r = mk2("'", "Y");
            8'd191: r = mk2("'", "W");
            8'd192: r = mk3("i", "'", "\"");
            8'd193: r = mk1("A");
            8'd194: r = mk1("V");
            8'd195: r = mk1("G");
            8'd196: r = mk1("D");
            8'd197: r = mk1("E");
            8'd198: r = mk1("Z");
            8'd199: r = mk1("H");
            8'd200: r = mk1("8");
            8'd201: r = mk1("I");
            8'd202: r = mk1("K");
            8'd203: r = mk1("L");
            8'd204: r = mk1("M");
            8'd205: r = mk1("N");
            8'd206: r = mk2("K", "S");
            8'd207: r = mk1("O");
            8'd208: r = mk1("P");
            8'd209: r = mk1("R");
            8'd211: r = mk1("S");
            8'd212: r = mk1("T");
            8'd213: r = mk1("Y");
            8'd214: r = mk1("F");
            8'd215: r = mk1("X");
            8'd216: r = mk2("P", "S");
            8'd217: r = mk1("W");
            8'd220: r = mk2("a", "'");
            8'd221: r = mk2("e", "'");
            8'd222: r = mk2("h", "'");
            8'd223: r = mk2("i", "'");
            8'd224: r = mk3("y", "'", "\"");
            8'd225: r = mk1("a");
            8'd226: r = mk1("v");
            8'd227: r = mk1("g");
            8'd228: r = mk1("d");
            8'd229: r = mk1("e");
            8'd230: r = mk1("z");
            8'd231: r = mk1("h");
            8'd232: r = mk1("8");
            8'd233: r = mk1("i");
            8'd234: r = mk1("k");
            8'd235: r = mk1("l");
            8'd236: r = mk1("m");
            8'd237: r = mk1("n");
            8'd238: r = mk2("k", "s");
            8'd239: r = mk1("o");
            8'd240: r = mk1("p");
            8'd241: r = mk1("r");
            8'd242: r = mk1("s");
            8'd243: r = mk1("s");
            8'd244: r = mk1("t");
            8'd245: r = mk1("y");
            8'd246: r = mk1("f");
            8'd247: r = mk1("x");
            8'd248: r = mk2("p", "s");
            8'd249: r = mk1("w");
            8'd250: r = mk2("i", "'");
            8'd251: r = mk2("y", "'");
            8'd252: r = mk2("o", "'");
            8'd253: r = mk2("y", "'");
            8'd254: r = mk2("w", "'");
            default: r = mk0();
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/greek_to_latin_transliterator.sv */
// An accepted request enters the input register, and its characters move on to
// the group register, which drives out_data, once that register is free.
// Throughput: one character per cycle while out_stall is low; a request gives
// n = 0..4 characters. The input register takes a new request while characters drain.
// Reset clears the pending letter and all valid flags.
// Top level; depends on gtl_pkg and gtl_xlat.
module greek_to_latin_transliterator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gtl_pkg::in_req_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output gtl_pkg::out_req_t out_data
);
    import gtl_pkg::*;

    in_req_t     in_data_reg;
    logic        in_valid_reg;
    pend_t       pend_reg;
    pend_t       pend_next;
    group_t      grp_next;
    char_t [MaxChars-1:0] chars_reg;
    logic [2:0]  cnt_reg;
    logic [1:0]  idx_reg;
    logic        grp_valid_reg;
    logic        out_last;
    logic        grp_done;
    logic        grp_free;
    logic        in_move;

    gtl_xlat u_xlat (
        .req       (in_data_reg),
        .pend      (pend_reg),
        .grp       (grp_next),
        .pend_next (pend_next)
    );

    assign out_last  = (({1'b0, idx_reg} + 3'd1) == cnt_reg);
    assign out_valid = grp_valid_reg;
    assign out_data  = '{out_char: chars_reg[idx_reg], last: out_last};
    assign grp_done  = grp_valid_reg && !out_stall && out_last;
    assign grp_free  = !grp_valid_reg || grp_done;
    assign in_move   = in_valid_reg && grp_free;
    assign in_stall  = in_valid_reg && !grp_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            grp_valid_reg <= 1'b0;
            pend_reg      <= PEND_NONE;
            idx_reg       <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                in_valid_reg <= 1'b1;
            else if (in_move)
                in_valid_reg <= 1'b0;

            if (in_move)
                pend_reg <= pend_next;

            if (in_move && grp_next.cnt != 3'd0)
            begin
                grp_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (grp_done)
                grp_valid_reg <= 1'b0;
            else if (grp_valid_reg && !out_stall)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_data_reg <= in_data;
        if (in_move && grp_next.cnt != 3'd0)
        begin
            chars_reg <= grp_next.chars;
            cnt_reg   <= grp_next.cnt;
        end
    end

endmodule

/* hw/rtl/gtl_xlat.sv */
// Combinational translation of one request: builds the character group and
// the next pending-letter code from the byte, end flag and pending code.
// Depends on gtl_pkg.
module gtl_xlat (
    input  gtl_pkg::in_req_t req,
    input  gtl_pkg::pend_t   pend,
    output gtl_pkg::group_t  grp,
    output gtl_pkg::pend_t   pend_next
);
    import gtl_pkg::*;

    xlat_t  tab;
    char_t  pch;
    logic   is_pi;
    logic   is_tau;

    assign tab    = xlat(req.in_byte);
    assign is_pi  = (req.in_byte == 8'd240) || (req.in_byte == 8'd208);
    assign is_tau = (req.in_byte == 8'd244) || (req.in_byte == 8'd212);

    always_comb
    begin
        case (pend)
            PEND_CAP_M: pch = 7'h4D;
            PEND_CAP_N: pch = 7'h4E;
            PEND_M:     pch = 7'h6D;
            PEND_N:     pch = 7'h6E;
            default:    pch = 7'h00;
        endcase
    end

    always_comb
    begin
        grp       = '0;
        pend_next = PEND_NONE;
        if (req.end_of_input)
        begin
            if (pend != PEND_NONE)
            begin
                grp.cnt      = 3'd1;
                grp.chars[0] = pch;
            end
        end
        else if (pend != PEND_NONE)
        begin
            grp.cnt = 3'd1;
            if (pend == PEND_CAP_M && is_pi)
                grp.chars[0] = 7'h42;
            else if (pend == PEND_M && is_pi)
                grp.chars[0] = 7'h62;
            else if (pend == PEND_CAP_N && is_tau)
                grp.chars[0] = 7'h44;
            else if (pend == PEND_N && is_tau)
                grp.chars[0] = 7'h64;
            else
            begin
                grp.cnt      = 3'd1 + {1'b0, tab.len};
                grp.chars[0] = pch;
                grp.chars[1] = tab.c0;
                grp.chars[2] = tab.c1;
                grp.chars[3] = tab.c2;
            end
        end
        else
        begin
            case (req.in_byte)
                8'd204:  pend_next = PEND_CAP_M;
                8'd205:  pend_next = PEND_CAP_N;
                8'd236:  pend_next = PEND_M;
                8'd237:  pend_next = PEND_N;
                default:
                begin
                    grp.cnt      = {1'b0, tab.len};
                    grp.chars[0] = tab.c0;
                    grp.chars[1] = tab.c1;
                    grp.chars[2] = tab.c2;
                end
            endcase
        end
    end

endmodule
